@@ design/bia_pkg.sv @@
// Shared types and constants for the bitmap index allocator.
// Used by bia_mark_ram, bia_ctrl and bitmap_index_allocator; no dependencies.
package bia_pkg;

  // Marks per memory row; a 6-bit index splits into a row and a bit position.
  localparam int ROW_W   = 8;
  localparam int IDX_W   = 6;
  localparam int ROWA_W  = 3;
  localparam int LIMIT_W = 7;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ROWA_W-1:0]  row_addr_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // Request kinds; the fourth code is unused and is rejected.
  typedef enum logic [1:0] {
    FN_ALLOC_ANY = 2'd0,
    FN_ALLOC_AT  = 2'd1,
    FN_FREE      = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_ALREADY   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  // Access to the mark memory: one row read, one row write per cycle.
  typedef struct packed {
    logic      rd_en;
    row_addr_t rd_addr;
    logic      wr_en;
    row_addr_t wr_addr;
    row_t      wr_data;
  } mem_req_t;

endpackage

@@ design/bia_mark_ram.sv @@
// Row-organized memory holding the allocated marks, with a registered read.
// Depends on bia_pkg; a valid bit per row makes unwritten rows read as zero.
module bia_mark_ram import bia_pkg::*; #(
  parameter int NUM_ROWS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t mem_req,
  output row_t     rd_data
);

  localparam int AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  row_t                mem_r [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld_r;
  row_t                rd_q_r;
  logic                rd_vld_r;

  // Write the modified row back
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_r[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
    end
  end

  // Mark rows as written; reset clears all marks at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_req.wr_en) begin
      row_vld_r[mem_req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // Register the read row and its valid bit
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_q_r   <= mem_r[mem_req.rd_addr[AW-1:0]];
      rd_vld_r <= row_vld_r[mem_req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ design/bia_ctrl.sv @@
// Request sequencer: range check, row read, modify and write back, result strobe.
// Depends on bia_pkg; drives bia_mark_ram through a mem_req_t.
module bia_ctrl import bia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  limit_t   limit,
  input  logic     start,
  output logic     busy,
  input  logic [1:0] in_func,
  input  idx_t     in_req_index,
  output mem_req_t mem_req,
  input  row_t     rd_data,
  output logic     out_valid,
  output idx_t     out_granted_index,
  output logic [2:0] out_status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] func_r, func_nxt;
  idx_t       idx_r, idx_nxt;
  row_addr_t  row_r, row_nxt;
  logic       out_valid_r, out_valid_nxt;
  idx_t       out_index_r, out_index_nxt;
  status_t    out_status_r, out_status_nxt;

  assign busy = (state_r != S_IDLE);

  // Scan one row: pick the lowest free mark below the limit
  logic [LIMIT_W-1:0] base;
  logic [ROW_W-1:0]   avail;
  logic               found;
  logic [2:0]         pick;
  logic               last_row;
  logic               sel_bit;

  always_comb begin
    base = {1'b0, row_r, 3'b000};
    for (int b = 0; b < ROW_W; b++) begin
      avail[b] = !rd_data[b] && ((base + LIMIT_W'(b)) < limit);
    end
    found = 1'b0;
    pick  = '0;
    for (int b = 0; b < ROW_W; b++) begin
      if (avail[b] && !found) begin
        found = 1'b1;
        pick  = 3'(b);
      end
    end
    last_row = (base + LIMIT_W'(ROW_W)) >= limit;
    sel_bit  = rd_data[idx_r[2:0]];
  end

  // Sequence the request and build the memory access
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    idx_nxt        = idx_r;
    row_nxt        = row_r;
    out_valid_nxt  = 1'b0;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    mem_req        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt      = in_func;
          idx_nxt       = in_req_index;
          out_index_nxt = '0;
          case (in_func)
            FN_ALLOC_ANY: begin
              if (limit == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NONE_FREE;
              end else begin
                row_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            FN_ALLOC_AT, FN_FREE: begin
              if ({1'b0, in_req_index} >= limit) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else begin
                row_nxt   = in_req_index[5:3];
                state_nxt = S_RD;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RANGE;
            end
          endcase
        end
      end
      S_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = row_r;
        state_nxt       = S_EVAL;
      end
      S_EVAL: begin
        // Write-back lands before any later read, so no forwarding is needed
        mem_req.wr_addr = row_r;
        mem_req.wr_data = rd_data;
        case (func_r)
          FN_ALLOC_ANY: begin
            if (found) begin
              mem_req.wr_en         = 1'b1;
              mem_req.wr_data[pick] = 1'b1;
              out_valid_nxt         = 1'b1;
              out_index_nxt         = {row_r, pick};
              out_status_nxt        = ST_OK;
              state_nxt             = S_IDLE;
            end else if (last_row) begin
              out_valid_nxt  = 1'b1;
              out_index_nxt  = '0;
              out_status_nxt = ST_NONE_FREE;
              state_nxt      = S_IDLE;
            end else begin
              row_nxt   = row_r + 3'd1;
              state_nxt = S_RD;
            end
          end
          FN_ALLOC_AT: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (sel_bit) begin
              out_index_nxt  = '0;
              out_status_nxt = ST_ALREADY;
            end else begin
              mem_req.wr_en                 = 1'b1;
              mem_req.wr_data[idx_r[2:0]]   = 1'b1;
              out_index_nxt                 = idx_r;
              out_status_nxt                = ST_OK;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (!sel_bit) begin
              out_index_nxt  = '0;
              out_status_nxt = ST_NOT_ALLOC;
            end else begin
              mem_req.wr_en                 = 1'b1;
              mem_req.wr_data[idx_r[2:0]]   = 1'b0;
              out_index_nxt                 = idx_r;
              out_status_nxt                = ST_OK;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold request and result payload
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    idx_r        <= idx_nxt;
    row_r        <= row_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_index_r;
  assign out_status        = out_status_r;

  // A failed request never reports an index
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_index_r == '0))
    else $error("nonzero index on failed result");

  // The result strobe only shows once the sequencer is back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while busy");

  // Every evaluation follows a row read
  a_eval_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> ($past(state_r) == S_RD))
    else $error("evaluation without a preceding read");

  // An in-range free request goes to the memory
  a_free_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_func == FN_FREE &&
     {1'b0, in_req_index} < limit) |=> (state_r == S_RD))
    else $error("in-range free did not read the marks");

endmodule

@@ design/bitmap_index_allocator.sv @@
// A rejected request (bad code, out of range, zero limit) strobes its result straight
// from the idle state; allocate-specific and free pass through a row read and an evaluate.
// Allocate-any reads one 8-mark row at a time until a free mark or the last row in range.
// One request at a time: start is taken only while idle, and busy is high during the row
// read and write-back loop. The receiver cannot stall. Reset clears every mark through
// per-row valid bits and sets entries_in_use to 64.
module bitmap_index_allocator import bia_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [5:0] in_req_index,
  output logic       out_valid,
  output logic [5:0] out_granted_index,
  output logic [2:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_entries_in_use
);

  localparam int     NUM_ROWS = (MAX_ENTRIES + ROW_W - 1) / ROW_W;
  localparam limit_t MAX_LIM  = LIMIT_W'(MAX_ENTRIES);

  limit_t   entries_r;
  limit_t   limit;
  mem_req_t mem_req;
  row_t     rd_data;

  assign cfg_ready = 1'b1;

  // Hold the entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= LIMIT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      entries_r <= cfg_entries_in_use;
    end
  end

  // Saturate the count at the size of the bitmap
  assign limit = (entries_r > MAX_LIM) ? MAX_LIM : entries_r;

  bia_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .limit             (limit),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_req_index      (in_req_index),
    .mem_req           (mem_req),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_granted_index (out_granted_index),
    .out_status        (out_status)
  );

  bia_mark_ram #(
    .NUM_ROWS (NUM_ROWS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule
